>>> hdl/transient_pool_aging_allocator_top_macros.svh
// Assertion macros used by the pool allocator engine.
`ifndef TRANSIENT_POOL_AGING_ALLOCATOR_TOP_MACROS_SVH
`define TRANSIENT_POOL_AGING_ALLOCATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TPAA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TPAA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TPAA_ASSERT_IMP(label, ante, cons, msg)
`define TPAA_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/tpaa_pkg.sv
// Shared types and constants of the pool allocator.
package tpaa_pkg;

	localparam int POOL_SLOTS_DEF = 64;
	localparam int KEY_BITS_DEF   = 32;
	localparam int AGE_W          = 6;
	localparam int CNT_W          = 7;
	localparam int SLOT_W         = 6;

	localparam logic [AGE_W-1:0] EVICT_AGE_RESET = 6'd60;
	localparam logic [AGE_W-1:0] AGE_MAX         = 6'd63;
	localparam logic [CNT_W-1:0] CNT_MAX         = 7'd127;

	// Register index of evict_age (byte address 0).
	localparam logic REG_EVICT_AGE = 1'b0;

	typedef enum logic [1:0] {
		ACT_REQUEST = 2'd0,
		ACT_RECYCLE = 2'd1,
		ACT_FRAME   = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_REUSED     = 3'd0,
		ST_CREATED    = 3'd1,
		ST_FULL       = 3'd2,
		ST_NOT_FOUND  = 3'd3,
		ST_RESET_DONE = 3'd4
	} status_t;

	typedef struct packed {
		logic [CNT_W-1:0]  evicted;
		logic [SLOT_W-1:0] slot;
		status_t           status;
	} result_t;

endpackage

>>> hdl/transient_pool_aging_allocator_top.sv
// Top level of the object pool allocator with age-based eviction.
//
// The s_ channel carries one command beat: request (find or create a pooled
// object for a kind and key), recycle (release a named slot) or frame reset
// (release every entry, age it and evict the stale ones). Command code 3 is
// dropped without a result. Every other command returns one beat on the m_
// channel with a status, the granted slot and the eviction count.
// The slot table lives in one synchronous RAM. A request or a frame reset
// walks all POOL_SLOTS entries through the single table read port, one
// read a cycle. One command is in flight at a time; the next one is
// accepted as soon as the result beat has moved into the output register,
// even if the receiver has not taken it. After reset the block clears the
// table, one entry a cycle, and holds s_tready low meanwhile; evict_age
// resets to 60 and can be written over APB at any time the block is idle.
// While m_tready is low the result beat holds in the output register and a
// following command waits in its final cycle until the register frees.
module transient_pool_aging_allocator_top import tpaa_pkg::*; #(
	parameter int POOL_SLOTS = POOL_SLOTS_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // action[1:0], desc_key[33:2], slot_in[39:34]
	input  logic [0:0]  s_tuser,   // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // status[2:0], slot_out[8:3], evicted_count[15:9]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [AGE_W-1:0] evict_age;
	logic             res_valid, res_ready;
	result_t          res;
	logic             m_tvalid_q;
	result_t          out_q;

	tpaa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.evict_age (evict_age)
	);

	// The key is compared in its low KEY_BITS bits.
	tpaa_engine #(
		.POOL_SLOTS (POOL_SLOTS),
		.KEY_BITS   (KEY_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.action    (s_tdata[1:0]),
		.kind      (s_tuser[0]),
		.key       (KEY_BITS'(s_tdata[33:2])),
		.slot_in   (s_tdata[39:34]),
		.evict_age (evict_age),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: loads whenever it is empty or being drained.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			out_q      <= '{evicted: '0, slot: '0, status: ST_REUSED};
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = 16'(out_q);

endmodule

>>> hdl/tpaa_ram.sv
// Generic simple dual-port RAM with registered read.
module tpaa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/tpaa_cfg.sv
// APB register file holding the eviction age.
module tpaa_cfg import tpaa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [AGE_W-1:0]  evict_age
);

	logic [AGE_W-1:0] evict_age_q;
	logic             hit_reg;

	assign pready  = 1'b1;
	assign hit_reg = (paddr[2] == REG_EVICT_AGE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evict_age_q <= EVICT_AGE_RESET;
		end else if (psel && penable && pwrite && pready && hit_reg) begin
			evict_age_q <= pwdata[AGE_W-1:0];
		end
	end

	assign prdata    = hit_reg ? 32'(evict_age_q) : 32'd0;
	assign evict_age = evict_age_q;

endmodule

>>> hdl/tpaa_engine.sv
// Slot table sequencer: clearing pass, lookup walk, recycle and frame aging.
`include "transient_pool_aging_allocator_top_macros.svh"
module tpaa_engine import tpaa_pkg::*; #(
	parameter int POOL_SLOTS = POOL_SLOTS_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic                kind,
	input  logic [KEY_BITS-1:0] key,
	input  logic [SLOT_W-1:0]   slot_in,
	input  logic [AGE_W-1:0]    evict_age,
	output logic                res_valid,
	input  logic                res_ready,
	output result_t             res
);

	localparam int AW = $clog2(POOL_SLOTS);
	localparam int CW = $clog2(POOL_SLOTS + 1);

	typedef struct packed {
		logic                valid;
		logic                kind;
		logic [KEY_BITS-1:0] key;
		logic                busy;
		logic [AGE_W-1:0]    age;
	} entry_t;

	localparam int EW = $bits(entry_t);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_RCY,
		S_FINISH
	} state_t;

	state_t              state_q;
	action_t             act_q;
	logic                kind_q;
	logic [KEY_BITS-1:0] key_q;
	logic [AW-1:0]       slot_q;
	logic [CW-1:0]       idx_q;
	logic                rd_v_s1;
	logic [AW-1:0]       rd_idx_s1;
	logic                hit_q, hole_q, ok_q;
	logic [AW-1:0]       hit_idx_q, hole_idx_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                rd_en, wr_en;
	logic [AW-1:0]       rd_addr, wr_addr;
	entry_t              wr_entry, rd_entry, aged;
	logic [EW-1:0]       rd_data;
	logic                in_acc, slot_ok, scan_more, rd_match, evict;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_ok   = 32'(slot_in) < 32'(POOL_SLOTS);
	assign scan_more = idx_q < CW'(POOL_SLOTS);
	assign rd_entry  = entry_t'(rd_data);
	assign rd_match  = rd_entry.valid && rd_entry.kind == kind_q && rd_entry.key == key_q;

	// Aging of one entry during a frame reset.
	always_comb begin
		aged       = rd_entry;
		aged.busy  = 1'b0;
		aged.age   = (rd_entry.age < AGE_MAX) ? rd_entry.age + 1'b1 : AGE_MAX;
		evict      = aged.age >= evict_age;
		aged.valid = !evict;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		if (state_q == S_SCAN && scan_more) begin
			rd_en = 1'b1;
		end else if (in_acc && action == ACT_RECYCLE && slot_ok) begin
			rd_en   = 1'b1;
			rd_addr = AW'(slot_in);
		end
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = idx_q[AW-1:0];
		wr_entry = '0;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_SCAN: begin
				if (rd_v_s1 && act_q == ACT_FRAME && rd_entry.valid) begin
					wr_en    = 1'b1;
					wr_addr  = rd_idx_s1;
					wr_entry = aged;
				end
			end
			S_RCY: begin
				wr_addr  = slot_q;
				wr_entry = rd_entry;
				wr_entry.busy = 1'b0;
				wr_en    = rd_match;
			end
			S_FINISH: begin
				wr_addr  = hit_q ? hit_idx_q : hole_idx_q;
				wr_entry = '{valid: 1'b1, kind: kind_q, key: key_q, busy: 1'b1, age: '0};
				wr_en    = res_ready && act_q == ACT_REQUEST && (hit_q || hole_q);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	tpaa_ram #(
		.WIDTH (EW),
		.DEPTH (POOL_SLOTS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (EW'(wr_entry)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		res = '{evicted: '0, slot: '0, status: ST_REUSED};
		case (act_q)
			ACT_REQUEST: begin
				if (hit_q) begin
					res.slot = SLOT_W'(hit_idx_q);
				end else if (hole_q) begin
					res.status = ST_CREATED;
					res.slot   = SLOT_W'(hole_idx_q);
				end else begin
					res.status = ST_FULL;
				end
			end
			ACT_RECYCLE: res.status = ok_q ? ST_REUSED : ST_NOT_FOUND;
			ACT_FRAME: begin
				res.status  = ST_RESET_DONE;
				res.evicted = cnt_q;
			end
			default: res.status = ST_NOT_FOUND;
		endcase
	end

	assign res_valid = (state_q == S_FINISH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			idx_q      <= '0;
			rd_v_s1    <= 1'b0;
			act_q      <= ACT_REQUEST;
			hit_q      <= 1'b0;
			hole_q     <= 1'b0;
			ok_q       <= 1'b0;
			cnt_q      <= '0;
			rd_idx_s1  <= '0;
			kind_q     <= 1'b0;
			key_q      <= '0;
			slot_q     <= '0;
			hit_idx_q  <= '0;
			hole_idx_q <= '0;
		end else begin
			rd_v_s1   <= rd_en && state_q == S_SCAN;
			rd_idx_s1 <= rd_addr;
			unique case (state_q)
				S_CLEAR: begin
					if (idx_q == CW'(POOL_SLOTS - 1)) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						kind_q <= kind;
						key_q  <= key;
						slot_q <= AW'(slot_in);
						idx_q  <= '0;
						hit_q  <= 1'b0;
						hole_q <= 1'b0;
						cnt_q  <= '0;
						case (action) inside
							ACT_REQUEST, ACT_FRAME: begin
								act_q   <= action_t'(action);
								state_q <= S_SCAN;
							end
							ACT_RECYCLE: begin
								act_q   <= ACT_RECYCLE;
								ok_q    <= 1'b0;
								state_q <= slot_ok ? S_RCY : S_FINISH;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_more) begin
						idx_q <= idx_q + 1'b1;
					end else if (!rd_v_s1) begin
						state_q <= S_FINISH;
					end
					if (rd_v_s1) begin
						if (act_q == ACT_REQUEST) begin
							if (rd_entry.valid) begin
								if (!hit_q && !rd_entry.busy && rd_match) begin
									hit_q     <= 1'b1;
									hit_idx_q <= rd_idx_s1;
								end
							end else if (!hole_q) begin
								hole_q     <= 1'b1;
								hole_idx_q <= rd_idx_s1;
							end
						end else if (rd_entry.valid && evict && cnt_q != CNT_MAX) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_RCY: begin
					ok_q    <= rd_match;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TPAA_ASSERT_IMP(a_no_rw_clash, rd_en && wr_en, rd_addr != wr_addr, "table read and write collide")
	`TPAA_ASSERT_IMP(a_walk_data, rd_v_s1, state_q == S_SCAN, "walk data outside the walk")
	`TPAA_ASSERT_NXT(a_finish_idle, res_valid && res_ready, state_q == S_IDLE, "result not retired")
	`TPAA_ASSERT_IMP(a_clear_blocks, state_q == S_CLEAR, !in_ready && wr_en, "clear pass leaks")

endmodule

>>> bench/tb_transient_pool_aging_allocator_top.sv
// Self-checking testbench of the pooled object allocator with age eviction.
module tb_transient_pool_aging_allocator_top import tpaa_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int              SLOTS       = POOL_SLOTS_DEF;
	localparam int              RAND_ITEMS  = 1550;
	// Cycles a request or frame reset may still be busy after its beat left.
	localparam int              SETTLE      = POOL_SLOTS_DEF + 8;
	localparam logic [1:0]      ACT_UNKNOWN = 2'd3;

	typedef struct {
		logic [1:0]              action;
		logic                    kind;
		logic [KEY_BITS_DEF-1:0] key;
		logic [SLOT_W-1:0]       slot;
	} pool_cmd_t;

	// One row of the directed plan: either a register write or a command beat,
	// the latter optionally with its result written out by hand.
	typedef struct {
		bit                      cfg;
		logic [1:0]              action;
		logic                    kind;
		logic [KEY_BITS_DEF-1:0] key;
		logic [SLOT_W-1:0]       slot;
		logic [AGE_W-1:0]        age;
		bit                      typed;
		status_t                 st;
		logic [SLOT_W-1:0]       so;
		logic [CNT_W-1:0]        ev;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // action[1:0], desc_key[33:2], slot_in[39:34]
	logic [0:0]  s_tuser;   // kind[0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // status[2:0], slot_out[8:3], evicted_count[15:9]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	transient_pool_aging_allocator_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Shadow copy of the slot table and of the eviction register.
	logic                    pool_valid [SLOTS];
	logic                    pool_kind  [SLOTS];
	logic [KEY_BITS_DEF-1:0] pool_key   [SLOTS];
	logic                    pool_busy  [SLOTS];
	logic [AGE_W-1:0]        pool_age   [SLOTS];
	logic [AGE_W-1:0]        evict_limit;

	result_t                 awaited_replies[$];
	logic [KEY_BITS_DEF-1:0] key_pool[8];
	int                      fail_count = 0;
	int                      burst_left = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Hard stop in case the block hangs or a beat never comes back.
	initial begin
		#(20_000_000);
		$display("FAILURE");
		$finish;
	end

	// Works out the allocator's answer to one command and updates the shadow
	// table. Returns 0 when the command yields no result beat.
	function automatic bit pool_respond(input pool_cmd_t c, output result_t r);
		int hit;
		int hole;
		logic [CNT_W-1:0] evicted;
		hit = -1;
		hole = -1;
		evicted = '0;
		r = '0;
		case (c.action)
			ACT_REQUEST: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (pool_valid[i]) begin
						if (hit < 0 && !pool_busy[i] && pool_kind[i] == c.kind &&
						    pool_key[i] == c.key)
							hit = i;
					end else if (hole < 0) begin
						hole = i;
					end
				end
				if (hit >= 0) begin
					pool_busy[hit] = 1'b1;
					pool_age[hit] = '0;
					r.status = ST_REUSED;
					r.slot = SLOT_W'(hit);
				end else if (hole >= 0) begin
					pool_valid[hole] = 1'b1;
					pool_kind[hole] = c.kind;
					pool_key[hole] = c.key;
					pool_busy[hole] = 1'b1;
					pool_age[hole] = '0;
					r.status = ST_CREATED;
					r.slot = SLOT_W'(hole);
				end else begin
					r.status = ST_FULL;
				end
			end
			ACT_RECYCLE: begin
				// A miss covers an empty slot and a kind or key mismatch; an
				// idle matching entry is released again without complaint.
				if (pool_valid[c.slot] && pool_kind[c.slot] == c.kind &&
				    pool_key[c.slot] == c.key) begin
					pool_busy[c.slot] = 1'b0;
					r.status = ST_REUSED;
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
			ACT_FRAME: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (pool_valid[i]) begin
						pool_busy[i] = 1'b0;
						if (pool_age[i] < AGE_MAX)
							pool_age[i] = pool_age[i] + 1'b1;
						if (pool_age[i] >= evict_limit) begin
							pool_valid[i] = 1'b0;
							if (evicted < CNT_MAX)
								evicted = evicted + 1'b1;
						end
					end
				end
				r.status = ST_RESET_DONE;
				r.evicted = evicted;
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// Keys mostly come from a small set so that reuse and filling happen often.
	function automatic logic [KEY_BITS_DEF-1:0] pick_key();
		if ($urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic pool_cmd_t draw_cmd(input int frame_pct);
		pool_cmd_t c;
		int roll;
		int start;
		int idx;
		c.action = ACT_REQUEST;
		c.kind = 1'($urandom_range(0, 1));
		c.key = $urandom;
		c.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
		roll = $urandom_range(0, 99);
		if (roll < frame_pct) begin
			c.action = ACT_FRAME;
		end else if (roll < frame_pct + 3) begin
			c.action = ACT_UNKNOWN;
		end else if (roll < frame_pct + 30) begin
			c.action = ACT_RECYCLE;
			if ($urandom_range(0, 9) < 7) begin
				// Aim at a live entry so the release path is really exercised.
				start = $urandom_range(0, SLOTS - 1);
				for (int k = 0; k < SLOTS; k++) begin
					idx = (start + k) % SLOTS;
					if (pool_valid[idx]) begin
						c.slot = SLOT_W'(idx);
						c.kind = pool_kind[idx];
						c.key = pool_key[idx];
						break;
					end
				end
			end else begin
				c.key = pick_key();
			end
		end else begin
			c.key = pick_key();
		end
		return c;
	endfunction

	// Sends one command beat. The sender moves in bursts with random gaps in
	// between; on acceptance the answer is predicted and queued.
	task automatic send_beat(input pool_cmd_t c, input bit use_typed, input result_t typed,
	                         output bit produced);
		int gap;
		result_t r;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {c.slot, c.key, c.action};
		s_tuser <= c.kind;
		do @(posedge clk); while (s_tready !== 1'b1);
		produced = pool_respond(c, r);
		if (produced)
			awaited_replies.push_back(use_typed ? typed : r);
	endtask

	// Drops valid and waits until every outstanding beat is back, then lets
	// a dropped command or a walk in progress settle.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
	                        output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_EVICT_AGE, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Reads back the current threshold first, which also checks its reset
	// value, then writes the new one with junk in the unused upper bits.
	task automatic set_evict_age(input logic [AGE_W-1:0] age);
		logic [31:0] rd;
		logic [31:0] wd;
		apb_xfer(1'b0, 32'd0, rd);
		if (rd[AGE_W-1:0] !== evict_limit) begin
			$error("evict_age: expected %0d, actual %0d", evict_limit, rd[AGE_W-1:0]);
			fail_count++;
		end
		wd = $urandom;
		wd[AGE_W-1:0] = age;
		apb_xfer(1'b1, wd, rd);
		evict_limit = age;
	endtask

	// Receiver: long stretches of steady readiness alternate with choppy
	// stall patterns.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 3) == 0) begin
				@(negedge clk);
				m_tready <= 1'b1;
				repeat ($urandom_range(50, 300)) @(negedge clk);
			end else begin
				repeat ($urandom_range(2, 10)) begin
					@(negedge clk);
					m_tready <= 1'b1;
					repeat ($urandom_range(0, 5)) @(negedge clk);
					@(negedge clk);
					m_tready <= 1'b0;
					repeat ($urandom_range(0, 7)) @(negedge clk);
				end
			end
		end
	end

	// Result checker: every beat taken must match the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (awaited_replies.size() == 0) begin
				$error("result beat with nothing outstanding: m_tdata %h", m_tdata);
				fail_count++;
			end else begin
				want = awaited_replies.pop_front();
				if (m_tdata[2:0] !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
					fail_count++;
				end
				if (m_tdata[8:3] !== want.slot) begin
					$error("slot_out: expected %0d, actual %0d", want.slot, m_tdata[8:3]);
					fail_count++;
				end
				if (m_tdata[15:9] !== want.evicted) begin
					$error("evicted_count: expected %0d, actual %0d", want.evicted,
					       m_tdata[15:9]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		plan_row_t plan[25];
		pool_cmd_t c;
		result_t typed;
		bit produced;
		int served;
		int phase;
		int phase_len;
		int frame_pct;
		logic [AGE_W-1:0] age;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < SLOTS; i++) begin
			pool_valid[i] = 1'b0;
			pool_kind[i] = 1'b0;
			pool_key[i] = '0;
			pool_busy[i] = 1'b0;
			pool_age[i] = '0;
		end
		evict_limit = EVICT_AGE_RESET;
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 32'h0000_0001;
		key_pool[3] = 32'h8000_0000;
		for (int i = 4; i < 8; i++)
			key_pool[i] = $urandom;

		// Directed plan. Hand-written results only where they are obvious:
		// first claims, misses, frame counts. The rest trust the predictor.
		plan = '{
			'{0, ACT_REQUEST, 0, 32'h0000_0000, 6'd0,  6'd0,  1, ST_CREATED,    6'd0, 7'd0},
			'{0, ACT_REQUEST, 1, 32'hFFFF_FFFF, 6'd63, 6'd0,  1, ST_CREATED,    6'd1, 7'd0},
			// Slot 0 is busy, so the same key takes a fresh slot.
			'{0, ACT_REQUEST, 0, 32'h0000_0000, 6'd0,  6'd0,  1, ST_CREATED,    6'd2, 7'd0},
			'{0, ACT_RECYCLE, 0, 32'h0000_0000, 6'd0,  6'd0,  1, ST_REUSED,     6'd0, 7'd0},
			'{0, ACT_REQUEST, 0, 32'h0000_0000, 6'd0,  6'd0,  1, ST_REUSED,     6'd0, 7'd0},
			// Misses: empty slot, wrong kind, wrong key.
			'{0, ACT_RECYCLE, 1, 32'hFFFF_FFFF, 6'd63, 6'd0,  1, ST_NOT_FOUND,  6'd0, 7'd0},
			'{0, ACT_RECYCLE, 0, 32'hFFFF_FFFF, 6'd1,  6'd0,  1, ST_NOT_FOUND,  6'd0, 7'd0},
			'{0, ACT_RECYCLE, 1, 32'hFFFF_FFFE, 6'd1,  6'd0,  1, ST_NOT_FOUND,  6'd0, 7'd0},
			// Releasing twice: the second hits an idle entry and still succeeds.
			'{0, ACT_RECYCLE, 0, 32'h0000_0000, 6'd2,  6'd0,  1, ST_REUSED,     6'd0, 7'd0},
			'{0, ACT_RECYCLE, 0, 32'h0000_0000, 6'd2,  6'd0,  1, ST_REUSED,     6'd0, 7'd0},
			// Unknown command code: swallowed without a result.
			'{0, ACT_UNKNOWN, 1, 32'hA5A5_A5A5, 6'd42, 6'd0,  0, ST_REUSED,     6'd0, 7'd0},
			'{0, ACT_FRAME,   0, 32'h0000_0000, 6'd0,  6'd0,  1, ST_RESET_DONE, 6'd0, 7'd0},
			'{0, ACT_REQUEST, 0, 32'h0000_0000, 6'd0,  6'd0,  1, ST_REUSED,     6'd0, 7'd0},
			'{0, ACT_REQUEST, 1, 32'h0000_0000, 6'd0,  6'd0,  1, ST_CREATED,    6'd3, 7'd0},
			// A zero threshold evicts every live entry at the next frame.
			'{1, ACT_REQUEST, 0, 32'h0000_0000, 6'd0,  6'd0,  0, ST_REUSED,     6'd0, 7'd0},
			'{0, ACT_FRAME,   1, 32'hFFFF_FFFF, 6'd63, 6'd0,  1, ST_RESET_DONE, 6'd0, 7'd4},
			'{0, ACT_REQUEST, 1, 32'h5A5A_5A5A, 6'd63, 6'd0,  1, ST_CREATED,    6'd0, 7'd0},
			'{1, ACT_REQUEST, 0, 32'h0000_0000, 6'd0,  6'd63, 0, ST_REUSED,     6'd0, 7'd0},
			'{0, ACT_FRAME,   0, 32'h0000_0000, 6'd0,  6'd0,  1, ST_RESET_DONE, 6'd0, 7'd0},
			'{1, ACT_REQUEST, 0, 32'h0000_0000, 6'd0,  6'd2,  0, ST_REUSED,     6'd0, 7'd0},
			'{0, ACT_FRAME,   0, 32'h0000_0000, 6'd0,  6'd0,  1, ST_RESET_DONE, 6'd0, 7'd1},
			'{1, ACT_REQUEST, 0, 32'h0000_0000, 6'd0,  6'd1,  0, ST_REUSED,     6'd0, 7'd0},
			'{0, ACT_REQUEST, 0, 32'h8000_0000, 6'd21, 6'd0,  0, ST_REUSED,     6'd0, 7'd0},
			'{0, ACT_FRAME,   0, 32'h0000_0000, 6'd0,  6'd0,  1, ST_RESET_DONE, 6'd0, 7'd1},
			'{0, ACT_RECYCLE, 0, 32'h8000_0000, 6'd0,  6'd0,  1, ST_NOT_FOUND,  6'd0, 7'd0}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].cfg) begin
				wait_drained();
				set_evict_age(plan[i].age);
			end else begin
				c.action = plan[i].action;
				c.kind = plan[i].kind;
				c.key = plan[i].key;
				c.slot = plan[i].slot;
				typed = '0;
				typed.status = plan[i].st;
				typed.slot = plan[i].so;
				typed.evicted = plan[i].ev;
				send_beat(c, plan[i].typed, typed, produced);
			end
		end

		// Random phases, each with its own threshold and frame rate. Low frame
		// rates let the table fill up and hit the full case.
		served = 0;
		phase = 0;
		while (served < RAND_ITEMS) begin
			wait_drained();
			case (phase % 6)
				0: age = AGE_MAX;
				1: age = 6'd1;
				2: age = 6'd0;
				3: age = EVICT_AGE_RESET;
				default: age = AGE_W'($urandom_range(2, 62));
			endcase
			set_evict_age(age);
			frame_pct = $urandom_range(2, 20);
			phase_len = $urandom_range(60, 220);
			for (int n = 0; n < phase_len && served < RAND_ITEMS; n++) begin
				// Now and then hold the sender until the pipe is empty.
				if ((phase == 0 && n == 30) || $urandom_range(0, 199) == 0)
					wait_drained();
				c = draw_cmd(frame_pct);
				send_beat(c, 1'b0, typed, produced);
				if (produced)
					served++;
			end
			phase++;
		end

		wait_drained();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
